// ----- rtl/ipow_pkg.sv -----
// Package for the signed integer power block: widths, payload types and core interface.
`timescale 1ns / 1ps
package ipow_pkg;

   localparam int DATA_WIDTH = 32;
   localparam int SIGN_POS   = DATA_WIDTH - 1;

   typedef struct packed {
      logic signed [DATA_WIDTH-1:0] base_value;
      logic signed [DATA_WIDTH-1:0] exponent_value;
   } ipow_req_type;

   typedef struct packed {
      logic                         result_valid;
      logic signed [DATA_WIDTH-1:0] power_result;
   } ipow_rsp_type;

   typedef struct packed {
      logic                  start;
      logic [DATA_WIDTH-1:0] base;
      logic [DATA_WIDTH-1:0] mag;
   } ipow_cmd_type;

   typedef struct packed {
      logic                  busy;
      logic                  done;
      logic [DATA_WIDTH-1:0] acc;
   } ipow_status_type;

endpackage

// ----- rtl/ipow_mul.sv -----
// Shared multiplier: low word of the product of two words.
`timescale 1ns / 1ps
module ipow_mul
   import ipow_pkg::*;
(
   input  logic [DATA_WIDTH-1:0] op_a,
   input  logic [DATA_WIDTH-1:0] op_b,
   output logic [DATA_WIDTH-1:0] product
);

   logic [2*DATA_WIDTH-1:0] full;

   always_comb begin
      full    = {{DATA_WIDTH{1'b0}}, op_a} * {{DATA_WIDTH{1'b0}}, op_b};
      product = full[DATA_WIDTH-1:0];
   end

endmodule

// ----- rtl/ipow_core.sv -----
// Square-and-multiply sequencer around the shared multiplier.
`timescale 1ns / 1ps
module ipow_core
   import ipow_pkg::*;
(
   input  logic            clock,
   input  logic            reset,
   input  ipow_cmd_type    cmd,
   output ipow_status_type status
);

   localparam logic PH_MUL = 1'b0;
   localparam logic PH_SQR = 1'b1;

   logic                  busy_ff, busy_in;
   logic                  done_ff, done_in;
   logic                  phase_ff, phase_in;
   logic [DATA_WIDTH-1:0] acc_ff, acc_in;
   logic [DATA_WIDTH-1:0] sq_ff, sq_in;
   logic [DATA_WIDTH-1:0] mag_ff, mag_in;
   logic [DATA_WIDTH-1:0] op_a;
   logic [DATA_WIDTH-1:0] product;
   logic                  rest_zero;

   assign op_a      = (phase_ff == PH_MUL) ? acc_ff : sq_ff;
   assign rest_zero = (mag_ff[DATA_WIDTH-1:1] == '0);

   ipow_mul u_mul (
      .op_a    (op_a),
      .op_b    (sq_ff),
      .product (product)
   );

   always_comb begin
      busy_in  = busy_ff;
      done_in  = 1'b0;
      phase_in = phase_ff;
      acc_in   = acc_ff;
      sq_in    = sq_ff;
      mag_in   = mag_ff;
      if (cmd.start) begin
         busy_in  = 1'b1;
         acc_in   = {{(DATA_WIDTH-1){1'b0}}, 1'b1};
         sq_in    = cmd.base;
         mag_in   = cmd.mag;
         phase_in = cmd.mag[0] ? PH_MUL : PH_SQR;
      end else if (busy_ff) begin
         unique case (phase_ff)
            PH_MUL: begin
               acc_in = product;
               if (rest_zero) begin
                  busy_in = 1'b0;
                  done_in = 1'b1;
               end else begin
                  phase_in = PH_SQR;
               end
            end
            PH_SQR: begin
               sq_in    = product;
               mag_in   = mag_ff >> 1;
               phase_in = mag_ff[1] ? PH_MUL : PH_SQR;
            end
            default: begin
               phase_in = PH_MUL;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff  <= 1'b0;
         done_ff  <= 1'b0;
         phase_ff <= PH_MUL;
      end else begin
         busy_ff  <= busy_in;
         done_ff  <= done_in;
         phase_ff <= phase_in;
      end
      acc_ff <= acc_in;
      sq_ff  <= sq_in;
      mag_ff <= mag_in;
   end

   assign status.busy = busy_ff;
   assign status.done = done_ff;
   assign status.acc  = acc_ff;

endmodule

// ----- rtl/signed_integer_power_top.sv -----
// Signed integer power: top level with handshakes, special cases and reciprocal fix-up.
// A zero base or zero exponent is answered without the core; otherwise the core takes a
// squaring for each exponent bit below the top set bit and a multiply for each set bit.
// One item at a time; a result waits in the output register while the next request is taken.
// Reset is synchronous and active high, and leaves the block idle with no result pending.
`timescale 1ns / 1ps
module signed_integer_power_top
   import ipow_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         req_valid,
   output logic         req_ready,
   input  ipow_req_type req_payload,
   output logic         rsp_valid,
   input  logic         rsp_ready,
   output ipow_rsp_type rsp_payload
);

   localparam logic [1:0] ST_IDLE = 2'd0;
   localparam logic [1:0] ST_RUN  = 2'd1;
   localparam logic [1:0] ST_DONE = 2'd2;

   logic [1:0]            state_ff, state_in;
   logic                  neg_ff, neg_in;
   ipow_rsp_type          pend_ff, pend_in;
   logic                  rsp_valid_ff, rsp_valid_in;
   ipow_rsp_type          rsp_ff, rsp_in;
   ipow_cmd_type          cmd;
   ipow_status_type       status;
   logic                  accept;
   logic                  base_zero;
   logic                  exp_zero;
   logic                  exp_neg;
   logic [DATA_WIDTH-1:0] exp_bits;
   logic [DATA_WIDTH-1:0] fixed;

   assign accept    = req_valid && req_ready;
   assign exp_bits  = req_payload.exponent_value;
   assign base_zero = (req_payload.base_value == '0);
   assign exp_zero  = (exp_bits == '0);
   assign exp_neg   = exp_bits[SIGN_POS];

   always_comb begin
      cmd.start = accept && !base_zero && !exp_zero;
      cmd.base  = req_payload.base_value;
      cmd.mag   = exp_neg ? (~exp_bits + {{(DATA_WIDTH-1){1'b0}}, 1'b1}) : exp_bits;
   end

   ipow_core u_core (
      .clock  (clock),
      .reset  (reset),
      .cmd    (cmd),
      .status (status)
   );

   always_comb begin
      fixed = status.acc;
      if (neg_ff) begin
         if (status.acc == {{(DATA_WIDTH-1){1'b0}}, 1'b1} || status.acc == '1) begin
            fixed = status.acc;
         end else begin
            fixed = '0;
         end
      end
   end

   always_comb begin
      state_in     = state_ff;
      neg_in       = neg_ff;
      pend_in      = pend_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_in       = rsp_ff;
      if (rsp_valid_ff && rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               neg_in = exp_neg;
               if (base_zero) begin
                  pend_in.result_valid = !(exp_neg || exp_zero);
                  pend_in.power_result = '0;
                  state_in             = ST_DONE;
               end else if (exp_zero) begin
                  pend_in.result_valid = 1'b1;
                  pend_in.power_result = {{(DATA_WIDTH-1){1'b0}}, 1'b1};
                  state_in             = ST_DONE;
               end else begin
                  state_in = ST_RUN;
               end
            end
         end
         ST_RUN: begin
            if (status.done) begin
               pend_in.result_valid = 1'b1;
               pend_in.power_result = fixed;
               state_in             = ST_DONE;
            end
         end
         ST_DONE: begin
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_valid_in = 1'b1;
               rsp_in       = pend_ff;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      neg_ff  <= neg_in;
      pend_ff <= pend_in;
      rsp_ff  <= rsp_in;
   end

   assign req_ready   = (state_ff == ST_IDLE) && !status.busy;
   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_ff;

endmodule

// ----- rtl/ipow_checker.sv -----
// Port-level checker for the signed integer power block, bound to the top level.
`timescale 1ns / 1ps
module ipow_port_checker
   import ipow_pkg::*;
(
   input logic         clock,
   input logic         reset,
   input logic         req_valid,
   input logic         req_ready,
   input ipow_req_type req_payload,
   input logic         rsp_valid,
   input logic         rsp_ready,
   input ipow_rsp_type rsp_payload
);

   // pending result holds until transfer
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_payload))
      else $error("result changed or dropped before transfer");

   // one item in flight: no new request right after a transfer
   a_busy: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("request taken while previous item in flight");

   // an invalid result carries zero
   a_invalid_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_payload.result_valid |-> rsp_payload.power_result == '0)
      else $error("invalid result with nonzero power");

   // idle with no result pending after reset
   a_reset_idle: assert property (@(posedge clock)
      reset |=> !rsp_valid && req_ready)
      else $error("block not idle after reset");

endmodule

bind signed_integer_power_top ipow_port_checker u_ipow_checker (.*);
